// ===== sv/bdqs_pkg.sv =====
`timescale 1ns / 1ps

package bdqs_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  // The value field is 32 bits wide, so at most 32 bits are kept per entry.
  localparam int STORE_W     = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_SEARCH     = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // What each cell does at the next edge.
  typedef enum logic [1:0] {
    CM_HOLD  = 2'd0,
    CM_LOAD  = 2'd1,
    CM_LEFT  = 2'd2,
    CM_RIGHT = 2'd3
  } cell_mode_e;

  typedef struct packed {
    logic             push_front;
    logic             push_back;
    logic             pop_front;
    logic [CNT_W-1:0] count;
  } row_ctl_t;

endpackage

// ===== sv/bounded_deque_with_search_core.sv =====
`timescale 1ns / 1ps
// Channel | Handshake            | Fields
// in      | in_valid / in_ready   | req_type, value
// out     | out_valid / out_ready | status, found, count
//
// Each item reads and updates the cell row at the edge
// at which it is accepted, and its result sits in the output register from
// the next cycle. One item per cycle is sustained while out_ready stays high.
// A result waiting for out_ready holds in_ready low; reset empties the queue
// and drops any pending result. Cell contents are not cleared by reset.

module bounded_deque_with_search_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    req_type,
  input  logic signed [31:0]            value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic                          found,
  output logic [bdqs_pkg::CNT_W-1:0]    count
);

  localparam int C = bdqs_pkg::CNT_W;
  localparam int W = bdqs_pkg::STORE_W;

  logic [C-1:0]        entry_count;
  logic [C-1:0]        entry_count_next;
  bdqs_pkg::status_e   st_next;
  bdqs_pkg::row_ctl_t  ctl;
  logic                accept;
  logic                full;
  logic                empty;
  logic                row_found;
  logic [W-1:0]        key;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (entry_count == C'(bdqs_pkg::DEPTH));
  assign empty    = (entry_count == '0);
  assign key      = value[W-1:0];

  always_comb begin
    ctl              = '0;
    ctl.count        = entry_count;
    st_next          = bdqs_pkg::ST_OK;
    entry_count_next = entry_count;
    case (req_type)
      bdqs_pkg::REQ_PUSH_FRONT, bdqs_pkg::REQ_PUSH_BACK: begin
        if (full) begin
          st_next = bdqs_pkg::ST_FULL;
        end else begin
          ctl.push_front   = accept && (req_type == bdqs_pkg::REQ_PUSH_FRONT);
          ctl.push_back    = accept && (req_type == bdqs_pkg::REQ_PUSH_BACK);
          entry_count_next = entry_count + C'(1);
        end
      end
      bdqs_pkg::REQ_POP_FRONT, bdqs_pkg::REQ_POP_BACK: begin
        if (empty) begin
          st_next = bdqs_pkg::ST_EMPTY;
        end else begin
          // Dropping the back only shrinks the count.
          ctl.pop_front    = accept && (req_type == bdqs_pkg::REQ_POP_FRONT);
          entry_count_next = entry_count - C'(1);
        end
      end
      default: ;
    endcase
  end

  bdqs_row u_row (
    .clk   (clk),
    .ctl   (ctl),
    .d_new (key),
    .key   (key),
    .found (row_found)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        entry_count <= entry_count_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= st_next;
      found  <= row_found && (req_type == bdqs_pkg::REQ_SEARCH);
      count  <= entry_count_next;
    end
  end

endmodule

// ===== sv/bdqs_cell.sv =====
`timescale 1ns / 1ps

module bdqs_cell (
  input  logic                                    clk,
  input  bdqs_pkg::cell_mode_e                    mode,
  input  logic [bdqs_pkg::STORE_W-1:0]            d_new,
  input  logic [bdqs_pkg::STORE_W-1:0]            d_left,
  input  logic [bdqs_pkg::STORE_W-1:0]            d_right,
  input  logic                                    occupied,
  input  logic [bdqs_pkg::STORE_W-1:0]            key,
  output logic [bdqs_pkg::STORE_W-1:0]            q,
  output logic                                    hit
);

  logic [bdqs_pkg::STORE_W-1:0] data;

  always_ff @(posedge clk) begin
    case (mode)
      bdqs_pkg::CM_LOAD:  data <= d_new;
      bdqs_pkg::CM_LEFT:  data <= d_left;
      bdqs_pkg::CM_RIGHT: data <= d_right;
      default:            data <= data;
    endcase
  end

  assign q   = data;
  assign hit = occupied && (data == key);

endmodule

// ===== sv/bdqs_row.sv =====
`timescale 1ns / 1ps

module bdqs_row (
  input  logic                           clk,
  input  bdqs_pkg::row_ctl_t             ctl,
  input  logic [bdqs_pkg::STORE_W-1:0]   d_new,
  input  logic [bdqs_pkg::STORE_W-1:0]   key,
  output logic                           found
);

  localparam int D = bdqs_pkg::DEPTH;
  localparam int W = bdqs_pkg::STORE_W;
  localparam int C = bdqs_pkg::CNT_W;

  logic [W-1:0] q    [D];
  logic [D-1:0] hits;

  // Cell 0 holds the front entry; the queue occupies cells 0 to count-1.
  for (genvar i = 0; i < D; i++) begin : g_cell
    bdqs_pkg::cell_mode_e mode;
    logic [W-1:0]         left_d;
    logic [W-1:0]         right_d;

    if (i == 0) begin : g_first
      assign left_d = d_new;
    end else begin : g_mid
      assign left_d = q[i-1];
    end
    if (i == D - 1) begin : g_last
      assign right_d = q[i];
    end else begin : g_inner
      assign right_d = q[i+1];
    end

    always_comb begin
      mode = bdqs_pkg::CM_HOLD;
      if (ctl.push_front) begin
        mode = (i == 0) ? bdqs_pkg::CM_LOAD : bdqs_pkg::CM_LEFT;
      end else if (ctl.push_back && (C'(i) == ctl.count)) begin
        mode = bdqs_pkg::CM_LOAD;
      end else if (ctl.pop_front) begin
        mode = bdqs_pkg::CM_RIGHT;
      end
    end

    bdqs_cell u_cell (
      .clk      (clk),
      .mode     (mode),
      .d_new    (d_new),
      .d_left   (left_d),
      .d_right  (right_d),
      .occupied (C'(i) < ctl.count),
      .key      (key),
      .q        (q[i]),
      .hit      (hits[i])
    );
  end

  assign found = |hits;

endmodule

// ===== sv/bdqs_checker.sv =====
`timescale 1ns / 1ps

module bdqs_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [1:0]                  status,
  input  logic                        found,
  input  logic [bdqs_pkg::CNT_W-1:0]  count
);

  localparam int C = bdqs_pkg::CNT_W;

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found)
      && $stable(count))
    else $error("stalled result changed");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == bdqs_pkg::ST_FULL) |-> count == C'(bdqs_pkg::DEPTH))
    else $error("full refusal with queue not full");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == bdqs_pkg::ST_EMPTY) |-> count == '0)
    else $error("empty refusal with entries held");

  a_found_sane: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> (status == bdqs_pkg::ST_OK) && (count != '0))
    else $error("found flag on an empty queue or refused item");

endmodule

bind bounded_deque_with_search_core bdqs_checker u_bdqs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .found     (found),
  .count     (count)
);

// ===== test/bounded_deque_with_search_core_tb.sv =====
`timescale 1ns / 1ps

module bounded_deque_with_search_core_tb;

  localparam int CNT_W = bdqs_pkg::CNT_W;
  localparam int DEPTH = bdqs_pkg::DEPTH;
  localparam int N_ROWS = 23;
  localparam int N_RANDOM = 500;
  localparam int MAX_GAP = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] REQ_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] REQ_LAST_UNUSED = 3'd7;
  localparam logic [31:0] POP_FILL = 32'h5A5A_5A5A;

  typedef struct packed {
    logic [1:0]       st;
    logic             fd;
    logic [CNT_W-1:0] cnt;
  } res_t;

  typedef struct {
    logic [2:0]  r;
    logic [31:0] v;
    bit          typed;
    res_t        res;
  } row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [2:0]              req_type = 3'd0;
  logic signed [31:0]      value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              status;
  logic                    found;
  logic [CNT_W-1:0]        count;

  // Shadow deque kept by the checker.
  logic [31:0] dq_mem [DEPTH];
  int          dq_head = 0;
  int          dq_cnt = 0;

  res_t  want_q [$];
  row_t  pin_q [$];
  int    n_err = 0;
  int    cycle_n = 0;
  bit    in_quiet = 1'b0;
  bit    out_quiet = 1'b0;
  row_t  plan [N_ROWS];

  bounded_deque_with_search_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .found     (found),
    .count     (count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, want_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic res_t deque_apply(logic [2:0] r, logic [31:0] v);
    res_t res;
    res.st = bdqs_pkg::ST_OK;
    res.fd = 1'b0;
    case (r)
      bdqs_pkg::REQ_PUSH_FRONT, bdqs_pkg::REQ_PUSH_BACK: begin
        if (dq_cnt >= DEPTH) begin
          res.st = bdqs_pkg::ST_FULL;
        end else if (r == bdqs_pkg::REQ_PUSH_FRONT) begin
          dq_head = (dq_head + DEPTH - 1) % DEPTH;
          dq_mem[dq_head] = v;
          dq_cnt++;
        end else begin
          dq_mem[(dq_head + dq_cnt) % DEPTH] = v;
          dq_cnt++;
        end
      end
      bdqs_pkg::REQ_POP_FRONT, bdqs_pkg::REQ_POP_BACK: begin
        if (dq_cnt == 0) begin
          res.st = bdqs_pkg::ST_EMPTY;
        end else begin
          if (r == bdqs_pkg::REQ_POP_FRONT) dq_head = (dq_head + 1) % DEPTH;
          dq_cnt--;
        end
      end
      bdqs_pkg::REQ_SEARCH: begin
        for (int k = 0; k < dq_cnt; k++)
          if (dq_mem[(dq_head + k) % DEPTH] == v) res.fd = 1'b1;
      end
      default: ;
    endcase
    res.cnt = CNT_W'(dq_cnt);
    return res;
  endfunction

  // Compare results against the oldest expectation; predict each accepted item.
  always @(posedge clk) begin : check
    res_t want;
    res_t calc;
    row_t tag;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d found %0d count %0d",
                   $time, status, found, count);
          n_err++;
        end else begin
          want = want_q.pop_front();
          if (status !== want.st) begin
            $display("%0t: status expected %0d got %0d", $time, want.st, status);
            n_err++;
          end
          if (found !== want.fd) begin
            $display("%0t: found expected %0d got %0d", $time, want.fd, found);
            n_err++;
          end
          if (count !== want.cnt) begin
            $display("%0t: count expected %0d got %0d", $time, want.cnt, count);
            n_err++;
          end
        end
      end
      if (in_valid && in_ready) begin
        calc = deque_apply(req_type, value);
        if (pin_q.size() != 0) begin
          tag = pin_q.pop_front();
          want_q.push_back(tag.typed ? tag.res : calc);
        end else begin
          want_q.push_back(calc);
        end
      end
    end
  end

  task automatic send_req(input row_t row);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pin_q.push_back(row);
    in_valid <= 1'b1;
    req_type <= row.r;
    value    <= row.v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (want_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value(logic [2:0] r);
    if (r == bdqs_pkg::REQ_SEARCH && dq_cnt > 0 && $urandom_range(0, 1) == 1)
      return dq_mem[(dq_head + $urandom_range(0, dq_cnt - 1)) % DEPTH];
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 15)) - 32'd8;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // mode: 0 fill, 1 drain, 2 mixed, 3 search-heavy
  function automatic logic [2:0] pick_req(int mode);
    int roll;
    int push_pct;
    int pop_pct;
    roll = $urandom_range(0, 99);
    case (mode)
      0: begin push_pct = 75; pop_pct = 15; end
      1: begin push_pct = 15; pop_pct = 75; end
      2: begin push_pct = 40; pop_pct = 40; end
      default: begin push_pct = 25; pop_pct = 25; end
    endcase
    if (roll < 3)
      return 3'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED));
    if (roll < 3 + push_pct)
      return $urandom_range(0, 1) ? bdqs_pkg::REQ_PUSH_FRONT : bdqs_pkg::REQ_PUSH_BACK;
    if (roll < 3 + push_pct + pop_pct)
      return $urandom_range(0, 1) ? bdqs_pkg::REQ_POP_FRONT : bdqs_pkg::REQ_POP_BACK;
    return bdqs_pkg::REQ_SEARCH;
  endfunction

  // Accept results with random stalls.
  initial begin : drain
    int stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      stall = out_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stim
    row_t row;
    int   n_real;
    int   blk_left;
    int   mode;
    int   blk_n;
    plan = '{
      '{bdqs_pkg::REQ_POP_FRONT,  POP_FILL,      1'b1, '{bdqs_pkg::ST_EMPTY, 1'b0, 5'd0}},
      '{bdqs_pkg::REQ_POP_BACK,   POP_FILL,      1'b1, '{bdqs_pkg::ST_EMPTY, 1'b0, 5'd0}},
      '{bdqs_pkg::REQ_SEARCH,     32'h0,         1'b1, '{bdqs_pkg::ST_OK,    1'b0, 5'd0}},
      '{REQ_FIRST_UNUSED,         32'h0,         1'b1, '{bdqs_pkg::ST_OK,    1'b0, 5'd0}},
      '{bdqs_pkg::REQ_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, '{bdqs_pkg::ST_OK,    1'b0, 5'd1}},
      '{bdqs_pkg::REQ_PUSH_FRONT, 32'h8000_0000, 1'b1, '{bdqs_pkg::ST_OK,    1'b0, 5'd2}},
      '{bdqs_pkg::REQ_SEARCH,     32'h8000_0000, 1'b0, '0},
      '{bdqs_pkg::REQ_SEARCH,     32'h7FFF_FFFF, 1'b0, '0},
      '{bdqs_pkg::REQ_SEARCH,     32'hFFFF_FFFF, 1'b0, '0},
      '{REQ_LAST_UNUSED,          32'hFFFF_FFFF, 1'b0, '0},
      '{bdqs_pkg::REQ_PUSH_BACK,  32'h0,         1'b0, '0},
      '{bdqs_pkg::REQ_POP_FRONT,  POP_FILL,      1'b0, '0},
      '{bdqs_pkg::REQ_SEARCH,     32'h8000_0000, 1'b0, '0},
      '{bdqs_pkg::REQ_POP_BACK,   POP_FILL,      1'b0, '0},
      '{bdqs_pkg::REQ_POP_FRONT,  POP_FILL,      1'b0, '0},
      '{bdqs_pkg::REQ_SEARCH,     32'h0,         1'b0, '0},
      '{bdqs_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, '0},
      '{bdqs_pkg::REQ_POP_BACK,   POP_FILL,      1'b0, '0},
      '{bdqs_pkg::REQ_PUSH_FRONT, 32'h1,         1'b0, '0},
      '{bdqs_pkg::REQ_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, '0},
      '{bdqs_pkg::REQ_SEARCH,     32'h5555_5555, 1'b0, '0},
      '{bdqs_pkg::REQ_POP_BACK,   POP_FILL,      1'b0, '0},
      '{bdqs_pkg::REQ_POP_BACK,   POP_FILL,      1'b0, '0}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) send_req(plan[i]);
    in_valid <= 1'b0;
    // Hold off until the directed items have all come back.
    wait_drained();

    n_real = 0;
    blk_left = 0;
    mode = 0;
    blk_n = 0;
    while (n_real < N_RANDOM) begin
      if (blk_left == 0) begin
        blk_left = $urandom_range(10, 40);
        mode = $urandom_range(0, 3);
        in_quiet = ($urandom_range(0, 3) == 0);
        out_quiet = ($urandom_range(0, 3) == 0);
        blk_n++;
        if (blk_n % 5 == 0) begin
          in_valid <= 1'b0;
          wait_drained();
        end
      end
      row.r = pick_req(mode);
      row.v = pick_value(row.r);
      row.typed = 1'b0;
      row.res = '0;
      send_req(row);
      blk_left--;
      if (row.r <= bdqs_pkg::REQ_SEARCH) n_real++;
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (n_err == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== bounded_deque_with_search_core.f =====
sv/bdqs_pkg.sv
sv/bdqs_cell.sv
sv/bdqs_row.sv
sv/bounded_deque_with_search_core.sv
sv/bdqs_checker.sv
test/bounded_deque_with_search_core_tb.sv
